/* rtl/core/psi_section_reassembler_unit_assert.svh */
// Assertion macros shared by the section reassembler RTL.
// Depends on i_clk and i_rst_n being present in the including module.
`ifndef PSI_SECTION_REASSEMBLER_UNIT_ASSERT_SVH
`define PSI_SECTION_REASSEMBLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PSR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("psr assertion failed");

// Next-cycle implication, checked outside reset.
`define PSR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("psr assertion failed");

`endif

/* rtl/core/psr_pkg.sv */
// Shared types and constants for the PSI section reassembler.
// No dependencies.
package psr_pkg;

    localparam int BUF_BYTES_DEF = 4096;
    localparam int PACKET_BYTES  = 188;
    localparam int ADDR_MAX_W    = 13;   // covers stores up to 8192 bytes
    localparam int SECT_W        = 13;
    localparam int EXP_W         = 13;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic KIND_READY = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // One operation for the back end: store write, store read, ready report.
    typedef struct packed {
        logic                  wr_en;
        logic                  rd_en;
        logic                  rd_oob;
        logic                  rdy_en;
        logic [ADDR_MAX_W-1:0] addr;
        logic [7:0]            data;
        logic [SECT_W-1:0]     count;
    } t_cmd;

endpackage

/* rtl/core/psr_front.sv */
// Front end: accepts requests, parses packet headers, tracks the open section.
// Depends on psr_pkg; issues t_cmd operations to the queue.
`include "psi_section_reassembler_unit_assert.svh"
module psr_front #(
    parameter int BUF_BYTES = psr_pkg::BUF_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic         i_req_type,
    input  logic [7:0]   i_data_byte,
    input  logic         i_packet_first,
    input  logic [11:0]  i_read_addr,
    input  logic         i_q_full,
    output logic         o_push,
    output psr_pkg::t_cmd o_cmd
);
    import psr_pkg::*;

    localparam int FW = $clog2(BUF_BYTES + 1);
    localparam int CW = (FW > EXP_W) ? FW : EXP_W;

    localparam logic [2:0] M_IGNORE   = 3'd0;
    localparam logic [2:0] M_HDR      = 3'd1;
    localparam logic [2:0] M_HDR_PUSI = 3'd2;
    localparam logic [2:0] M_CONT     = 3'd4;
    localparam logic [2:0] M_NEW      = 3'd5;
    localparam logic [2:0] M_CONT_AF  = 3'd6;
    localparam logic [2:0] M_NEW_AF   = 3'd7;

    logic [7:0]       r_idx,  n_idx;
    logic [2:0]       r_mode, n_mode;
    logic [8:0]       r_psa,  n_psa;
    logic [FW-1:0]    r_fill, n_fill;
    logic [EXP_W-1:0] r_exp,  n_exp;
    logic             r_open, n_open;

    logic [7:0]       bi;
    logic [2:0]       mode_now;
    logic [FW-1:0]    fill_now;
    logic [EXP_W-1:0] exp_now;
    logic [8:0]       off;
    logic             accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign bi         = 8'(r_idx + 8'd1);
    assign off        = 9'd5 + {1'b0, i_data_byte};

    always_comb begin
        n_idx    = r_idx;
        n_mode   = r_mode;
        n_psa    = r_psa;
        n_fill   = r_fill;
        n_exp    = r_exp;
        n_open   = r_open;
        mode_now = r_mode;
        fill_now = r_fill;
        exp_now  = r_exp;
        o_cmd    = '0;
        o_push   = 1'b0;
        if (accept) begin
            if (i_req_type == REQ_READ) begin
                o_push       = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.addr   = ADDR_MAX_W'(i_read_addr);
                o_cmd.rd_oob = ({20'd0, i_read_addr} >= 32'(BUF_BYTES));
            end else if (i_packet_first) begin
                n_idx  = '0;
                n_mode = M_HDR;
            end else if (r_mode != M_IGNORE) begin
                n_idx = bi;
                if (bi == 8'd1) begin
                    if (i_data_byte[7]) begin
                        // transport error: drop any partial section
                        n_fill = '0;
                        n_exp  = '0;
                        n_open = 1'b0;
                        n_mode = M_IGNORE;
                    end else if (i_data_byte[6]) begin
                        n_mode = M_HDR_PUSI;
                    end
                end else if (bi == 8'd3) begin
                    n_psa = 9'd4;
                    if (!i_data_byte[4]) begin
                        n_mode = M_IGNORE;
                    end else if (r_mode == M_HDR_PUSI) begin
                        n_fill = '0;
                        n_exp  = EXP_W'(3);
                        n_open = 1'b1;
                        n_mode = i_data_byte[5] ? M_NEW_AF : M_NEW;
                    end else if (r_open) begin
                        n_mode = i_data_byte[5] ? M_CONT_AF : M_CONT;
                    end else begin
                        n_mode = M_IGNORE;
                    end
                end else if (bi != 8'd2) begin
                    if (bi == 8'd4 && (r_mode == M_CONT_AF || r_mode == M_NEW_AF)) begin
                        n_psa    = (off > 9'(PACKET_BYTES)) ? 9'(PACKET_BYTES) : off;
                        mode_now = (r_mode == M_CONT_AF) ? M_CONT : M_NEW;
                    end else if ((r_mode == M_CONT || r_mode == M_NEW)
                                 && {1'b0, bi} >= r_psa) begin
                        if (r_mode == M_NEW) begin
                            if ({1'b0, bi} == 9'(r_psa + 9'd2)) begin
                                exp_now = EXP_W'(3) + {1'b0, i_data_byte[3:0], 8'h00};
                            end else if ({1'b0, bi} == 9'(r_psa + 9'd3)) begin
                                exp_now = r_exp + {5'd0, i_data_byte};
                            end
                        end
                        if (r_fill < FW'(BUF_BYTES)) begin
                            o_push      = 1'b1;
                            o_cmd.wr_en = 1'b1;
                            o_cmd.addr  = ADDR_MAX_W'(r_fill);
                            o_cmd.data  = i_data_byte;
                            fill_now    = r_fill + FW'(1);
                        end
                    end
                    n_mode = mode_now;
                    n_fill = fill_now;
                    n_exp  = exp_now;
                    // last byte of the packet: report a complete section
                    if (bi >= 8'(PACKET_BYTES - 1)) begin
                        if ((mode_now == M_CONT || mode_now == M_NEW)
                            && CW'(fill_now) >= CW'(exp_now)) begin
                            o_push       = 1'b1;
                            o_cmd.rdy_en = 1'b1;
                            o_cmd.count  = SECT_W'(fill_now);
                            n_fill       = '0;
                            n_open       = 1'b0;
                        end
                        n_mode = M_IGNORE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_mode <= M_IGNORE;
            r_psa  <= 9'd4;
            r_fill <= '0;
            r_exp  <= '0;
            r_open <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_mode <= n_mode;
            r_psa  <= n_psa;
            r_fill <= n_fill;
            r_exp  <= n_exp;
            r_open <= n_open;
        end
    end

    `PSR_ASSERT_IMP(a_mode_needs_open, r_mode[2], r_open)
    `PSR_ASSERT_IMP(a_fill_in_range, 1'b1, r_fill <= FW'(BUF_BYTES))
    `PSR_ASSERT_NXT(a_push_blocked_when_full, i_q_full, !$past(o_push))

endmodule

/* rtl/core/psr_fifo.sv */
// Short operation queue between the front and back ends.
// Depends on psr_pkg for t_cmd and the queue depth.
`include "psi_section_reassembler_unit_assert.svh"
module psr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  psr_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output psr_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import psr_pkg::*;

    t_cmd              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `PSR_ASSERT_NXT(a_count_up, i_push && !pop, r_count == $past(r_count) + QCNT_W'(1))
    `PSR_ASSERT_NXT(a_count_down, pop && !i_push, r_count == $past(r_count) - QCNT_W'(1))

endmodule

/* rtl/core/psr_back.sv */
// Back end: section store, registered read stage and output register.
// Depends on psr_pkg; consumes t_cmd operations from the queue.
`include "psi_section_reassembler_unit_assert.svh"
module psr_back #(
    parameter int BUF_BYTES = psr_pkg::BUF_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  psr_pkg::t_cmd             i_cmd,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_result_kind,
    output logic [psr_pkg::SECT_W-1:0] o_section_bytes,
    output logic [7:0]                o_read_data
);
    import psr_pkg::*;

    localparam int AW = $clog2(BUF_BYTES);

    logic [7:0]        r_store [BUF_BYTES];
    logic [7:0]        r_rd_q;
    logic              r_s1_valid;
    logic              r_s1_kind;
    logic              r_s1_oob;
    logic [SECT_W-1:0] r_s1_count;
    logic              r_o_valid;
    logic              r_o_kind;
    logic [SECT_W-1:0] r_o_bytes;
    logic [7:0]        r_o_data;
    logic              s1_adv;

    assign s1_adv = r_s1_valid && (!r_o_valid || i_out_ready);
    assign o_pop  = i_q_valid && (!r_s1_valid || s1_adv);

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.wr_en) begin
            r_store[i_cmd.addr[AW-1:0]] <= i_cmd.data;
        end
        if (o_pop && i_cmd.rd_en && !i_cmd.rd_oob) begin
            r_rd_q <= r_store[i_cmd.addr[AW-1:0]];
        end
    end

    // Read stage: hold the result while the output register is occupied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_pop) begin
            r_s1_valid <= i_cmd.rd_en || i_cmd.rdy_en;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_kind  <= i_cmd.rd_en ? KIND_READ : KIND_READY;
            r_s1_oob   <= i_cmd.rd_oob;
            r_s1_count <= i_cmd.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_kind  <= r_s1_kind;
            r_o_bytes <= (r_s1_kind == KIND_READ) ? '0 : r_s1_count;
            r_o_data  <= (r_s1_kind == KIND_READ && !r_s1_oob) ? r_rd_q : 8'd0;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_result_kind   = r_o_kind;
    assign o_section_bytes = r_o_bytes;
    assign o_read_data     = r_o_data;

    `PSR_ASSERT_NXT(a_s1_holds, r_s1_valid && !s1_adv, r_s1_valid)
    `PSR_ASSERT_NXT(a_out_loaded, s1_adv, r_o_valid && r_o_kind == $past(r_s1_kind))

endmodule

/* rtl/core/psi_section_reassembler_unit.sv */
// Path: a request is parsed by the front end and written to the queue, then passes
// the store read stage and the output register before it shows on o_out_valid.
// Throughput: one request per cycle while the queue is not full; output back-pressure can fill it.
// Reset (i_rst_n, synchronous, active low) clears parser state, queue and output
// valid; the section store is not cleared and reads of unwritten bytes are undefined.
// Top level: instantiates psr_front, psr_fifo and psr_back; depends on psr_pkg.
module psi_section_reassembler_unit #(
    parameter int BUF_BYTES = psr_pkg::BUF_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_req_type,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_packet_first,
    input  logic [11:0]                i_read_addr,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_result_kind,
    output logic [psr_pkg::SECT_W-1:0] o_section_bytes,
    output logic [7:0]                 o_read_data
);
    import psr_pkg::*;

    // Operations travelling from the parser to the store side.
    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd back_cmd;

    // Parse headers, follow the open section, emit store writes, reads and
    // section-ready reports; stall input only while the queue is full.
    psr_front #(
        .BUF_BYTES (BUF_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_data_byte    (i_data_byte),
        .i_packet_first (i_packet_first),
        .i_read_addr    (i_read_addr),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_cmd          (front_cmd)
    );

    // Decouple the parser from output back-pressure; order is preserved so a
    // read always sees every earlier write.
    psr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (back_cmd),
        .i_pop   (q_pop)
    );

    // Carry out operations against the store and present results.
    psr_back #(
        .BUF_BYTES (BUF_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_cmd           (back_cmd),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_section_bytes (o_section_bytes),
        .o_read_data     (o_read_data)
    );

endmodule

/* tb/sv/psi_section_reassembler_checker.sv */
// Checker for the PSI section reassembler: watches both transfer channels,
// predicts every result from the accepted requests and compares field by field.
// Depends on psr_pkg for widths and the request and result codes.
`timescale 1ns / 100ps

module psi_section_reassembler_checker #(
    parameter int BUF_BYTES = psr_pkg::BUF_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_req_type,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_packet_first,
    input  logic [11:0]                i_read_addr,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_result_kind,
    input  logic [psr_pkg::SECT_W-1:0] i_section_bytes,
    input  logic [7:0]                 i_read_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_written_span,
    output int                         o_sections_seen
);
    import psr_pkg::*;

    // Packet parse phase; the two _AF phases wait for the adaptation-field length.
    typedef enum logic [2:0] {
        PM_IDLE         = 3'd0,
        PM_HEADER       = 3'd1,
        PM_HEADER_START = 3'd2,
        PM_APPEND       = 3'd4,
        PM_OPEN         = 3'd5,
        PM_APPEND_AF    = 3'd6,
        PM_OPEN_AF      = 3'd7
    } t_pkt_phase;

    typedef struct packed {
        logic              kind;
        logic [SECT_W-1:0] bytes;
        logic [7:0]        data;
    } t_reply;

    t_reply      replies_due[$];
    t_reply      head_reply;
    logic [7:0]  shadow_store [BUF_BYTES];
    int unsigned fill_count;
    int unsigned target_len;
    int unsigned byte_pos;
    int unsigned payload_from;
    bit          section_live;
    t_pkt_phase  phase;

    initial o_fail_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        o_fail_count++;
        $display("@%0t %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Advance the shadow reassembler by one accepted request.
    task automatic reassemble_request(input logic req, input logic [7:0] b,
                                      input logic first, input logic [11:0] addr);
        t_reply      r;
        int unsigned off;
        int unsigned pos;
        if (req == REQ_READ) begin
            r.kind  = KIND_READ;
            r.bytes = '0;
            r.data  = (addr < BUF_BYTES) ? shadow_store[addr] : 8'h00;
            replies_due.push_back(r);
            return;
        end
        if (first) begin
            byte_pos = 0;
            phase    = PM_HEADER;
            return;
        end
        if (phase == PM_IDLE)
            return;
        byte_pos++;
        if (byte_pos == 1) begin
            if (b[7]) begin
                fill_count   = 0;
                target_len   = 0;
                section_live = 1'b0;
                phase        = PM_IDLE;
            end else if (b[6]) begin
                phase = PM_HEADER_START;
            end
            return;
        end
        if (byte_pos == 2)
            return;
        if (byte_pos == 3) begin
            payload_from = 4;
            if (!b[4]) begin
                phase = PM_IDLE;
            end else if (phase == PM_HEADER_START) begin
                fill_count   = 0;
                target_len   = 3;
                section_live = 1'b1;
                phase        = b[5] ? PM_OPEN_AF : PM_OPEN;
            end else if (section_live) begin
                phase = b[5] ? PM_APPEND_AF : PM_APPEND;
            end else begin
                phase = PM_IDLE;
            end
            return;
        end
        if (byte_pos == 4 && (phase == PM_APPEND_AF || phase == PM_OPEN_AF)) begin
            off          = 5 + b;
            payload_from = (off > PACKET_BYTES) ? PACKET_BYTES : off;
            phase        = (phase == PM_OPEN_AF) ? PM_OPEN : PM_APPEND;
        end else if ((phase == PM_APPEND || phase == PM_OPEN) && byte_pos >= payload_from) begin
            pos = byte_pos - payload_from;
            if (phase == PM_OPEN && pos == 2)
                target_len = 3 + 256 * b[3:0];
            else if (phase == PM_OPEN && pos == 3)
                target_len = target_len + b;
            if (fill_count < BUF_BYTES) begin
                shadow_store[fill_count] = b;
                fill_count++;
                if (fill_count > o_written_span)
                    o_written_span = fill_count;
            end
        end
        if (byte_pos >= PACKET_BYTES - 1) begin
            if ((phase == PM_APPEND || phase == PM_OPEN) && fill_count >= target_len) begin
                r.kind  = KIND_READY;
                r.bytes = fill_count[SECT_W-1:0];
                r.data  = 8'h00;
                replies_due.push_back(r);
                fill_count   = 0;
                section_live = 1'b0;
            end
            phase = PM_IDLE;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            replies_due.delete();
            fill_count      = 0;
            target_len      = 0;
            byte_pos        = 0;
            payload_from    = 4;
            section_live    = 1'b0;
            phase           = PM_IDLE;
            o_written_span  = 0;
            o_sections_seen = 0;
        end else begin
            if (i_in_valid && i_in_ready)
                reassemble_request(i_req_type, i_data_byte, i_packet_first, i_read_addr);
            if (i_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("result with nothing outstanding, kind",
                                    int'(i_result_kind), -1);
                end else begin
                    head_reply = replies_due.pop_front();
                    if (i_result_kind !== head_reply.kind)
                        report_mismatch("result_kind", int'(i_result_kind),
                                        int'(head_reply.kind));
                    if (i_section_bytes !== head_reply.bytes)
                        report_mismatch("section_bytes", int'(i_section_bytes),
                                        int'(head_reply.bytes));
                    if (i_read_data !== head_reply.data)
                        report_mismatch("read_data", int'(i_read_data),
                                        int'(head_reply.data));
                    if (head_reply.kind == KIND_READY)
                        o_sections_seen++;
                end
            end
        end
        o_pending = replies_due.size();
    end

endmodule

/* tb/sv/psi_section_reassembler_unit_test.sv */
// Top of the PSI section reassembler testbench: makes packet and read traffic,
// paces both channels and gives the verdict from the checker's failure count.
// Depends on psr_pkg, psi_section_reassembler_unit and psi_section_reassembler_checker.
`timescale 1ns / 100ps

module psi_section_reassembler_unit_test;
    import psr_pkg::*;

    localparam int IDLE_LIMIT   = 4000;   // cycles with no transfer on either side
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int TOTAL_ITEMS  = 1400;   // requests to offer over the whole run
    localparam int DRAIN_CYCLES = 20;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_req_type;
    logic [7:0]        i_data_byte;
    logic              i_packet_first;
    logic [11:0]       i_read_addr;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_result_kind;
    logic [SECT_W-1:0] o_section_bytes;
    logic [7:0]        o_read_data;

    int fail_count;
    int pending;
    int written_span;
    int sections_seen;

    int items_taken  = 0;
    int reads_taken  = 0;
    int packets_sent = 0;
    int holds_done   = 0;
    int send_quiet   = 0;
    int recv_quiet   = 0;
    int idle_cycles  = 0;
    bit hold_request = 1'b0;

    psi_section_reassembler_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_data_byte     (i_data_byte),
        .i_packet_first  (i_packet_first),
        .i_read_addr     (i_read_addr),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_section_bytes (o_section_bytes),
        .o_read_data     (o_read_data)
    );

    psi_section_reassembler_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_data_byte     (i_data_byte),
        .i_packet_first  (i_packet_first),
        .i_read_addr     (i_read_addr),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_result_kind   (o_result_kind),
        .i_section_bytes (o_section_bytes),
        .i_read_data     (o_read_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_written_span  (written_span),
        .o_sections_seen (sections_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Random wait per transfer; now and then a long stretch with no waits at all.
    function automatic int draw_gap(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            quiet_left = $urandom_range(30, 120);
        return $urandom_range(0, 6);
    endfunction

    // Payload bytes in one packet, after the header and any adaptation field.
    function automatic int payload_len(input bit af, input int af_len);
        if (!af)
            return PACKET_BYTES - 4;
        return (5 + af_len >= PACKET_BYTES) ? 0 : PACKET_BYTES - 5 - af_len;
    endfunction

    // Offer one request and hold it until it is transferred. Entered and left at a
    // falling edge; valid is left high so that a back-to-back request keeps it up.
    task automatic send_item(input logic req, input logic [7:0] b, input logic first,
                             input logic [11:0] addr);
        int gap;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_data_byte    <= b;
        i_packet_first <= first;
        i_read_addr    <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        items_taken++;
        if (req == REQ_READ)
            reads_taken++;
    endtask

    // Read back a byte that has been written at some point; skip while nothing is stored.
    // Data and packet_first ride along at random: a read must not disturb the parser.
    task automatic send_read();
        logic [11:0] addr;
        if (written_span == 0)
            return;
        if ($urandom_range(0, 7) == 0)
            addr = 12'(written_span - 1);
        else
            addr = 12'($urandom_range(0, written_span - 1));
        send_item(REQ_READ, 8'($urandom), 1'($urandom_range(0, 1)), addr);
    endtask

    // Push one transport packet, byte 0 flagged by packet_first. Stop early at stop_at
    // to abandon it. On a start packet payload bytes 2 and 3 carry the section length.
    task automatic send_packet(input bit tei, input bit pusi, input bit af, input bit pay,
                               input int af_len, input int sect_len, input int stop_at,
                               input int read_pct);
        int         pay_start;
        int         pos;
        logic [7:0] b;
        pay_start = PACKET_BYTES - payload_len(af, af_len);
        send_item(REQ_PUSH, 8'($urandom), 1'b1, 12'($urandom));
        for (int k = 1; k < stop_at; k++) begin
            if ($urandom_range(0, 99) < read_pct)
                send_read();
            b   = 8'($urandom);
            pos = k - pay_start;
            case (k)
                1: b = {tei, pusi, b[5:0]};
                3: b = {b[7:6], af, pay, b[3:0]};
                4: if (af) b = af_len[7:0];
                default: begin
                    if (pusi && pos == 2)
                        b[3:0] = sect_len[11:8];
                    else if (pusi && pos == 3)
                        b = sect_len[7:0];
                end
            endcase
            send_item(REQ_PUSH, b, 1'b0, 12'($urandom));
        end
        packets_sent++;
    endtask

    // Well-formed section: a start packet, then continuation packets until the
    // declared length is reached.
    task automatic send_section(input int sect_len, input int read_pct);
        int target;
        int held;
        int af_len;
        bit af;
        target = 3 + sect_len;
        af     = ($urandom_range(0, 3) == 0);
        af_len = $urandom_range(0, 20);
        send_packet(1'b0, 1'b1, af, 1'b1, af_len, sect_len, PACKET_BYTES, read_pct);
        held = payload_len(af, af_len);
        while (held < target) begin
            af     = ($urandom_range(0, 3) == 0);
            af_len = ($urandom_range(0, 7) == 0) ? $urandom_range(183, 255)
                                                 : $urandom_range(0, 60);
            send_packet(1'b0, 1'b0, af, 1'b1, af_len, 0, PACKET_BYTES, read_pct);
            held += payload_len(af, af_len);
        end
    endtask

    // Drop valid and hold off the sender until every expected result has arrived.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // Result side: random back-pressure per transfer, plus one long hold-off on request.
    initial begin : sink_side
        int gap;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
                holds_done++;
            end
            gap = draw_gap(recv_quiet);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("@%0t no transfer for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : source_side
        int pick;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_req_type     = REQ_PUSH;
        i_data_byte    = 8'h00;
        i_packet_first = 1'b0;
        i_read_addr    = 12'h000;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed part ----
        // Stray bytes before any packet start: ignored.
        repeat (3) send_item(REQ_PUSH, 8'($urandom), 1'b0, 12'($urandom));
        // Zero length field: section of 3 completes within one packet.
        send_packet(1'b0, 1'b1, 1'b0, 1'b1, 0, 0, PACKET_BYTES, 0);
        send_item(REQ_READ, 8'hFF, 1'b1, 12'd0);
        send_item(REQ_READ, 8'h00, 1'b0, 12'd183);
        // Hold the result side off for a long stretch and keep reads coming so the
        // block fills up and drops o_in_ready; then let everything drain.
        hold_request = 1'b1;
        repeat (40) send_read();
        wait_drained();
        // Start whose adaptation field leaves two payload bytes, so the length bytes
        // never arrive; a plain continuation then closes the section.
        send_packet(1'b0, 1'b1, 1'b1, 1'b1, 181, 0, PACKET_BYTES, 0);
        send_packet(1'b0, 1'b0, 1'b0, 1'b1, 0, 0, PACKET_BYTES, 5);
        // Error bit mid-section drops it; the next continuation is ignored.
        send_packet(1'b0, 1'b1, 1'b0, 1'b1, 0, 400, PACKET_BYTES, 0);
        send_packet(1'b1, 1'b0, 1'b0, 1'b1, 0, 0, 8, 0);
        send_packet(1'b0, 1'b0, 1'b0, 1'b1, 0, 0, 20, 0);
        // Early packet start abandons a packet; its stored bytes stay.
        send_packet(1'b0, 1'b1, 1'b0, 1'b1, 0, 10, 100, 0);
        send_packet(1'b0, 1'b0, 1'b0, 1'b1, 0, 0, PACKET_BYTES, 0);
        // No payload on a start packet.
        send_packet(1'b0, 1'b1, 1'b0, 1'b0, 0, 20, 12, 0);
        // Stray bytes after it.
        repeat (2) send_item(REQ_PUSH, 8'($urandom), 1'b0, 12'($urandom));
        wait_drained();

        // ---- random part: short sections, broken headers, strays and reads ----
        while (items_taken < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_section($urandom_range(0, 181), $urandom_range(0, 20));
            end else if (pick < 80) begin
                // Any header at all, mostly abandoned part-way.
                send_packet(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            $urandom_range(0, 255), $urandom,
                            (pick < 75) ? $urandom_range(2, PACKET_BYTES - 1) : PACKET_BYTES,
                            $urandom_range(0, 10));
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 5))
                    send_item(REQ_PUSH, 8'($urandom), 1'b0, 12'($urandom));
            end else begin
                repeat ($urandom_range(1, 12)) send_read();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Covered %0d packets and %0d requests (%0d store reads), %0d sections reported.",
                 packets_sent, items_taken, reads_taken, sections_seen);
        $display("Store filled up to %0d bytes; result side held off %0d time(s).",
                 written_span, holds_done);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
